>>> rtl/cccv_pkg.sv
// ----------------------------------------------------------------------------
// cccv_pkg: shared types and constants of the CC/CV charge controller
// Step and mode codes, voltage thresholds, register indexes and the
// controller state record passed between the update logic and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package cccv_pkg;

  // Parameter defaults
  localparam int DUTY_MAX_DEF        = 1000;
  localparam int TIMEOUT_MINUTES_DEF = 360;

  // Field widths
  localparam int DUTY_W = 10;
  localparam int MV_W   = 12;
  localparam int ADC_W  = 12;
  localparam int CUR_W  = 10;
  localparam int MIN_W  = 9;
  localparam int CFG_W  = 12;
  localparam int CUR_MA_W = 12;  // measured current in mA, at most 3290

  // Voltage thresholds in mV
  localparam logic [MV_W-1:0] MV_CV_INIT     = 12'd1650;
  localparam logic [MV_W-1:0] MV_CV_ENTER    = 12'd1660;
  localparam logic [MV_W-1:0] MV_OVERVOLT    = 12'd1720;
  localparam logic [MV_W-1:0] MV_RAMP_MIN    = 12'd1100;
  localparam logic [MV_W-1:0] MV_TIMER_CLEAR = 12'd1600;

  localparam logic [CUR_W-1:0] RAMP_START   = 10'd50;
  localparam int               CV_START     = 500;
  localparam logic [8:0]       SENSE_GAIN   = 9'd330;   // scaled by 1/4096
  localparam logic signed [3:0] HYST_LIMIT  = 4'sd5;
  localparam logic [2:0]       OV_TICKS     = 3'd3;     // exit on the tick after this many
  localparam logic [2:0]       OV_EXIT_CNT  = 3'd4;
  localparam logic [MIN_W-1:0] MIN_SAT      = 9'd511;

  // Configuration register reset values
  localparam logic [CUR_W-1:0] TARGET_CURRENT_RST = 10'd600;
  localparam logic [MV_W-1:0]  FULL_VOLTAGE_RST   = 12'd1800;
  localparam logic [CUR_W-1:0] FINISH_CURRENT_RST = 10'd100;
  localparam logic [ADC_W-1:0] BASELINE_ADC_RST   = 12'd0;

  typedef enum logic [1:0] {
    REG_TARGET_CURRENT = 2'd0,
    REG_FULL_VOLTAGE   = 2'd1,
    REG_FINISH_CURRENT = 2'd2,
    REG_BASELINE_ADC   = 2'd3
  } cfg_index_t;

  typedef enum logic [2:0] {
    ST_IDLE     = 3'd0,
    ST_INIT     = 3'd1,
    ST_CHARGING = 3'd2,
    ST_FINISHED = 3'd3,
    ST_EXIT     = 3'd4
  } step_t;

  typedef enum logic [1:0] {
    MD_CC  = 2'd0,
    MD_CV  = 2'd1,
    MD_FIN = 2'd2
  } mode_t;

  typedef struct packed {
    logic [CUR_W-1:0] target_current;
    logic [MV_W-1:0]  full_voltage;
    logic [CUR_W-1:0] finish_current;
    logic [ADC_W-1:0] baseline_adc;
  } cfg_t;

  typedef struct packed {
    step_t              step;
    mode_t              mode;
    logic [DUTY_W-1:0]  duty;
    logic [CUR_W-1:0]   ramp;
    logic [1:0]         prescale;
    logic [2:0]         overvolt;
    logic signed [3:0]  hyst;
    logic [MIN_W-1:0]   minutes;
    logic               led_green;
  } ctrl_state_t;

endpackage

`default_nettype wire

>>> rtl/cccv_update.sv
// ----------------------------------------------------------------------------
// cccv_update: one control tick of the charge sequencer
// Computes the next controller state and duty setpoint from the current
// state, the configuration and one input transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module cccv_update #(
  parameter int DUTY_MAX        = cccv_pkg::DUTY_MAX_DEF,
  parameter int TIMEOUT_MINUTES = cccv_pkg::TIMEOUT_MINUTES_DEF,
  parameter int SP_W            = $clog2(DUTY_MAX + 1)
) (
  input  cccv_pkg::ctrl_state_t          st,
  input  logic [SP_W-1:0]                sp,
  input  cccv_pkg::cfg_t                 cfg,
  input  logic                           power_enable,
  input  logic [cccv_pkg::MV_W-1:0]      battery_mv,
  input  logic [cccv_pkg::ADC_W-1:0]     current_adc,
  input  logic                           minute_tick,
  output cccv_pkg::ctrl_state_t          nx,
  output logic [SP_W-1:0]                sp_next,
  output logic                           chime
);

  localparam int CV_SP = (cccv_pkg::CV_START < DUTY_MAX) ? cccv_pkg::CV_START : DUTY_MAX;
  localparam logic [SP_W-1:0] SP_MAX   = SP_W'(DUTY_MAX);
  localparam logic [SP_W-1:0] SP_CV    = SP_W'(CV_SP);
  localparam logic [cccv_pkg::MIN_W-1:0] TIMEOUT = cccv_pkg::MIN_W'(TIMEOUT_MINUTES);

  logic [cccv_pkg::ADC_W-1:0]    diff;
  logic [20:0]                   prod;
  logic [cccv_pkg::CUR_MA_W-1:0] cur_tens;
  logic [cccv_pkg::CUR_MA_W-1:0] cur_ma;
  logic [cccv_pkg::CUR_MA_W-1:0] ramp_ext;
  logic [cccv_pkg::CUR_MA_W-1:0] finish_ext;
  logic                          over_mv;
  logic                          ov_exit;
  logic signed [3:0]             hyst_up;
  logic signed [3:0]             hyst_dn;
  cccv_pkg::step_t               step_eff;

  // Charge current in mA: ((baseline - adc) * 330 / 4096) * 10, zero unless adc is below baseline
  always_comb begin
    diff     = cfg.baseline_adc - current_adc;
    prod     = 21'(diff) * 21'(cccv_pkg::SENSE_GAIN);
    cur_tens = cccv_pkg::CUR_MA_W'(prod[20:12]);
    if (current_adc < cfg.baseline_adc) begin
      cur_ma = (cur_tens << 3) + (cur_tens << 1);
    end else begin
      cur_ma = '0;
    end
  end

  assign over_mv    = battery_mv > cccv_pkg::MV_OVERVOLT;
  assign ov_exit    = over_mv && (st.overvolt >= cccv_pkg::OV_TICKS);
  assign hyst_up    = st.hyst + 4'sd1;
  assign hyst_dn    = st.hyst - 4'sd1;
  assign finish_ext = cccv_pkg::CUR_MA_W'(cfg.finish_current);

  always_comb begin
    nx       = st;
    sp_next  = sp;
    chime    = 1'b0;
    ramp_ext = '0;

    if (minute_tick && (st.minutes != cccv_pkg::MIN_SAT)) begin
      nx.minutes = st.minutes + 1'b1;
    end

    // power off forces the exit step unless already idle
    if (!power_enable && (st.step != cccv_pkg::ST_IDLE)) begin
      step_eff = cccv_pkg::ST_EXIT;
    end else begin
      step_eff = st.step;
    end

    if (power_enable || (st.step != cccv_pkg::ST_IDLE)) begin
      unique case (step_eff)
        cccv_pkg::ST_IDLE: begin
          nx.step = cccv_pkg::ST_INIT;
        end
        cccv_pkg::ST_INIT: begin
          nx.minutes   = '0;
          chime        = 1'b1;
          nx.led_green = 1'b0;
          if (battery_mv < cccv_pkg::MV_CV_INIT) begin
            nx.mode = cccv_pkg::MD_CC;
            sp_next = '0;
          end else begin
            nx.mode = cccv_pkg::MD_CV;
            sp_next = SP_CV;
          end
          nx.duty     = '0;
          nx.overvolt = '0;
          nx.ramp     = cccv_pkg::RAMP_START;
          nx.hyst     = '0;
          nx.step     = cccv_pkg::ST_CHARGING;
        end
        cccv_pkg::ST_CHARGING: begin
          nx.prescale = st.prescale + 2'd1;
          if (over_mv) begin
            nx.overvolt = ov_exit ? cccv_pkg::OV_EXIT_CNT : st.overvolt + 3'd1;
          end else begin
            nx.overvolt = '0;
          end

          if (ov_exit) begin
            // hold duty; the exit step runs on the next transaction
            nx.step = cccv_pkg::ST_EXIT;
          end else if (nx.minutes > TIMEOUT) begin
            sp_next      = '0;
            nx.step      = cccv_pkg::ST_FINISHED;
            nx.led_green = 1'b1;
            nx.mode      = cccv_pkg::MD_FIN;
            if (battery_mv <= cccv_pkg::MV_TIMER_CLEAR) begin
              nx.minutes = '0;
              nx.mode    = cccv_pkg::MD_CC;
            end
            nx.duty = '0;
          end else begin
            if (battery_mv > cccv_pkg::MV_RAMP_MIN) begin
              if ((nx.prescale == 2'd0) && (st.ramp < cfg.target_current)) begin
                nx.ramp = st.ramp + 1'b1;
              end
            end else begin
              nx.ramp = cccv_pkg::RAMP_START;
            end
            ramp_ext = cccv_pkg::CUR_MA_W'(nx.ramp);

            case (st.mode)
              cccv_pkg::MD_CC: begin
                if (battery_mv >= cccv_pkg::MV_CV_ENTER) begin
                  nx.mode = cccv_pkg::MD_CV;
                end else if (cur_ma > ramp_ext) begin
                  if (sp > SP_W'(2)) sp_next = sp - 1'b1;
                end else if (cur_ma < ramp_ext) begin
                  if ((nx.prescale == 2'd0) && (sp < SP_MAX)) sp_next = sp + 1'b1;
                end
              end
              cccv_pkg::MD_CV: begin
                if (battery_mv > cfg.full_voltage) begin
                  if (hyst_up >= cccv_pkg::HYST_LIMIT) begin
                    nx.hyst = '0;
                    if (sp != '0) sp_next = sp - 1'b1;
                  end else begin
                    nx.hyst = hyst_up;
                  end
                  if (cur_ma < finish_ext) nx.mode = cccv_pkg::MD_FIN;
                end else begin
                  if (hyst_dn <= -cccv_pkg::HYST_LIMIT) begin
                    nx.hyst = '0;
                    if (sp < SP_MAX) sp_next = sp + 1'b1;
                  end else begin
                    nx.hyst = hyst_dn;
                  end
                end
              end
              cccv_pkg::MD_FIN: begin
                sp_next      = '0;
                nx.step      = cccv_pkg::ST_FINISHED;
                nx.led_green = 1'b1;
                if (battery_mv <= cccv_pkg::MV_TIMER_CLEAR) begin
                  nx.minutes = '0;
                  nx.mode    = cccv_pkg::MD_CC;
                end
              end
              default: begin
                nx.mode = cccv_pkg::MD_FIN;
              end
            endcase
            nx.duty = cccv_pkg::DUTY_W'(sp_next);
          end
        end
        cccv_pkg::ST_FINISHED: begin
          nx.led_green = 1'b1;
        end
        cccv_pkg::ST_EXIT: begin
          nx.duty      = '0;
          nx.led_green = 1'b1;
          nx.step      = cccv_pkg::ST_IDLE;
        end
        default: begin
          nx.step = cccv_pkg::ST_EXIT;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/cc_cv_battery_charge_controller_top.sv
// ----------------------------------------------------------------------------
// cc_cv_battery_charge_controller_top: CC/CV battery charge controller
//
// One input transaction is one control tick: power switch, battery mV,
// averaged current-sense sample and a minute flag. Each tick produces one
// result transaction with the PWM duty, sequencer step, charge mode, start
// chime and LED color.
// Both channels use valid/ready. The tick is evaluated in a single pass of
// logic from the controller state registers and lands in the output register;
// out_valid rises in the cycle after acceptance.
// Throughput is one transaction per cycle: in_ready stays high while the
// output register is empty or is being taken in the same cycle, so a stalled
// receiver holds in_ready low only while a finished result is still waiting.
// Configuration is a plain write port (cfg_write, cfg_index, cfg_data); the user
// writes it while no tick is in flight, the block itself does not enforce this.
// Synchronous reset returns the sequencer to idle, CC mode, duty 0, ramp 50
// and the register defaults, and empties the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module cc_cv_battery_charge_controller_top #(
  parameter int DUTY_MAX        = cccv_pkg::DUTY_MAX_DEF,
  parameter int TIMEOUT_MINUTES = cccv_pkg::TIMEOUT_MINUTES_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // configuration
  input  wire logic                          cfg_write,
  input  wire logic [1:0]                    cfg_index,
  input  wire logic [cccv_pkg::CFG_W-1:0]    cfg_data,
  // tick input
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          power_enable,
  input  wire logic [cccv_pkg::MV_W-1:0]     battery_mv,
  input  wire logic [cccv_pkg::ADC_W-1:0]    current_adc,
  input  wire logic                          minute_tick,
  // result output
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [cccv_pkg::DUTY_W-1:0]        pwm_duty,
  output logic [2:0]                         charge_step,
  output logic [1:0]                         chg_mode,
  output logic                               start_chime,
  output logic                               battery_led_green
);

  localparam int SP_W = $clog2(DUTY_MAX + 1);

  cccv_pkg::cfg_t        cfg;
  cccv_pkg::ctrl_state_t state;
  cccv_pkg::ctrl_state_t state_next;
  logic [SP_W-1:0]       setpoint;
  logic [SP_W-1:0]       setpoint_next;
  logic                  chime_next;
  logic                  in_fire;

  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.target_current <= cccv_pkg::TARGET_CURRENT_RST;
      cfg.full_voltage   <= cccv_pkg::FULL_VOLTAGE_RST;
      cfg.finish_current <= cccv_pkg::FINISH_CURRENT_RST;
      cfg.baseline_adc   <= cccv_pkg::BASELINE_ADC_RST;
    end else if (cfg_write) begin
      unique case (cccv_pkg::cfg_index_t'(cfg_index))
        cccv_pkg::REG_TARGET_CURRENT: cfg.target_current <= cfg_data[cccv_pkg::CUR_W-1:0];
        cccv_pkg::REG_FULL_VOLTAGE:   cfg.full_voltage   <= cfg_data;
        cccv_pkg::REG_FINISH_CURRENT: cfg.finish_current <= cfg_data[cccv_pkg::CUR_W-1:0];
        cccv_pkg::REG_BASELINE_ADC:   cfg.baseline_adc   <= cfg_data;
        default: ;
      endcase
    end
  end

  cccv_update #(
    .DUTY_MAX        (DUTY_MAX),
    .TIMEOUT_MINUTES (TIMEOUT_MINUTES),
    .SP_W            (SP_W)
  ) u_update (
    .st           (state),
    .sp           (setpoint),
    .cfg          (cfg),
    .power_enable (power_enable),
    .battery_mv   (battery_mv),
    .current_adc  (current_adc),
    .minute_tick  (minute_tick),
    .nx           (state_next),
    .sp_next      (setpoint_next),
    .chime        (chime_next)
  );

  // Controller state advances once per accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      state.step      <= cccv_pkg::ST_IDLE;
      state.mode      <= cccv_pkg::MD_CC;
      state.duty      <= '0;
      state.ramp      <= cccv_pkg::RAMP_START;
      state.prescale  <= '0;
      state.overvolt  <= '0;
      state.hyst      <= '0;
      state.minutes   <= '0;
      state.led_green <= 1'b0;
      setpoint        <= '0;
    end else if (in_fire) begin
      state    <= state_next;
      setpoint <= setpoint_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      pwm_duty          <= state_next.duty;
      charge_step       <= state_next.step;
      chg_mode          <= state_next.mode;
      start_chime       <= chime_next;
      battery_led_green <= state_next.led_green;
    end
  end

  // A chime only goes out with the tick that enters charging
  a_chime_step: assert property (@(posedge clk) disable iff (rst)
    (out_valid && start_chime) |-> (charge_step == cccv_pkg::ST_CHARGING))
    else $error("chime without entry to charging");

  // Power off always lands the sequencer in idle
  a_power_off_idle: assert property (@(posedge clk) disable iff (rst)
    (in_fire && !power_enable) |=> (state.step == cccv_pkg::ST_IDLE))
    else $error("power off did not return to idle");

  // Duty is zero outside charging until init has run
  a_idle_duty: assert property (@(posedge clk) disable iff (rst)
    ((state.step == cccv_pkg::ST_IDLE) || (state.step == cccv_pkg::ST_INIT))
      |-> (state.duty == '0))
    else $error("nonzero duty in idle or init");

  a_setpoint_max: assert property (@(posedge clk) disable iff (rst)
    setpoint <= SP_W'(DUTY_MAX))
    else $error("setpoint above duty limit");

  a_hyst_range: assert property (@(posedge clk) disable iff (rst)
    (state.hyst < cccv_pkg::HYST_LIMIT) && (state.hyst > -cccv_pkg::HYST_LIMIT))
    else $error("hysteresis count out of range");

  a_finished_green: assert property (@(posedge clk) disable iff (rst)
    (state.step == cccv_pkg::ST_FINISHED) |-> state.led_green)
    else $error("finished without green indicator");

endmodule

`default_nettype wire
